// ----- design/hs_pkg.sv -----
`default_nettype none

package hs_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   typedef enum logic [0:0] {
      ST_LOAD  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cmd_type;

endpackage

`default_nettype wire

// ----- design/hs_cell.sv -----
`default_nettype none

module hs_cell (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire hs_pkg::cmd_type                        cmd,
   input  wire logic signed [hs_pkg::DATA_WIDTH-1:0]   req_value,
   input  wire logic                                   left_gt,
   input  wire logic signed [hs_pkg::DATA_WIDTH-1:0]   left_value,
   input  wire logic                                   left_valid,
   input  wire logic signed [hs_pkg::DATA_WIDTH-1:0]   right_value,
   input  wire logic                                   right_valid,
   output logic signed [hs_pkg::DATA_WIDTH-1:0]        value,
   output logic                                        valid,
   output logic                                        gt
);

   logic signed [hs_pkg::DATA_WIDTH-1:0] value_ff;
   logic signed [hs_pkg::DATA_WIDTH-1:0] value_in;
   logic                                 valid_ff;
   logic                                 valid_in;

   // an empty cell counts as holding +infinity
   assign gt    = !valid_ff || (value_ff > req_value);
   assign value = value_ff;
   assign valid = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.load) begin
         if (gt) begin
            value_in = left_gt ? left_value : req_value;
            valid_in = valid_ff | left_valid;
         end
      end else if (cmd.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/hs_ctrl.sv -----
`default_nettype none

module hs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic             full,
   input  wire logic             tail,
   output logic                  overflow,
   output hs_pkg::cmd_type       cmd
);

   hs_pkg::state_type state_ff;
   hs_pkg::state_type state_in;
   logic              overflow_ff;
   logic              overflow_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hs_pkg::ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         hs_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = !full;
               if (full) begin
                  overflow_in = 1'b1;
               end
               if (req_last) begin
                  state_in = hs_pkg::ST_DRAIN;
               end
            end
         end
         hs_pkg::ST_DRAIN: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift = 1'b1;
               if (tail) begin
                  state_in    = hs_pkg::ST_LOAD;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = hs_pkg::ST_LOAD;
         end
      endcase
   end

   assign overflow = overflow_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("load and drain active together");

   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> rsp_valid)
      else $error("drain did not follow last transfer");

   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !full)
      else $error("insert into full chain");

   a_overflow_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid)) |-> $stable(overflow))
      else $error("overflow changed during drain");

endmodule

`default_nettype wire

// ----- design/heap_sorter_top.sv -----
// heap_sorter_top: sorts a set of signed 32-bit values into ascending order.
// Input channel req_: one value per transfer, req_last marks the final value
// of the set. Up to CAPACITY values are kept; further values are dropped and
// every result of that set then carries rsp_overflow. A dropped value marked
// last still ends the set.
// Result channel rsp_: the set in ascending order, one value per transfer,
// rsp_last_res on the largest.
// Storage is a row of CAPACITY cells kept in sorted order: each accepted
// value is inserted by a parallel compare in every cell, the larger values
// moving one cell to the right. Loading accepts one value per cycle.
// The first result is shown in the cycle after the last input transfer;
// results then leave at 1 per cycle while rsp_ready is high, as the row
// shifts toward cell 0. Input is not accepted while a set is being drained.
// A stall on rsp_ready simply holds the row and the shown result.
// Reset (synchronous) empties all cells and clears the overflow flag; no
// clearing pass is needed.
`default_nettype none

module heap_sorter_top #(
   parameter int CAPACITY = hs_pkg::CAPACITY
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [hs_pkg::DATA_WIDTH-1:0]  req_value,
   input  wire logic                                  req_last,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [hs_pkg::DATA_WIDTH-1:0]       rsp_value_res,
   output logic                                       rsp_last_res,
   output logic                                       rsp_overflow
);

   hs_pkg::cmd_type                      cmd;
   logic signed [hs_pkg::DATA_WIDTH-1:0] cell_value [0:CAPACITY];
   logic                                 cell_valid [0:CAPACITY];
   logic                                 cell_gt    [0:CAPACITY-1];

   assign cell_value[CAPACITY] = '0;
   assign cell_valid[CAPACITY] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                 left_gt;
      logic signed [hs_pkg::DATA_WIDTH-1:0] left_value;
      logic                                 left_valid;
      if (i == 0) begin : g_head
         assign left_gt    = 1'b0;
         assign left_value = req_value;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_gt    = cell_gt[i-1];
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end
      hs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .req_value   (req_value),
         .left_gt     (left_gt),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (cell_value[i+1]),
         .right_valid (cell_valid[i+1]),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   hs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .full      (cell_valid[CAPACITY-1]),
      .tail      (rsp_last_res),
      .overflow  (rsp_overflow),
      .cmd       (cmd)
   );

   assign rsp_value_res = cell_value[0];
   assign rsp_last_res  = !cell_valid[1];

endmodule

`default_nettype wire
